>>> hw/rtl/bire_pkg.sv
// Shared types and constants of the bilevel image run-length encoder.
package bire_pkg;

	localparam int TOT_W        = 21;  // total_pixels register width
	localparam int PIX_PER_WORD = 8;   // pixels carried by one input word
	localparam int TAKE_W       = 4;   // holds 0..PIX_PER_WORD
	localparam int RUN_MIN      = 8;   // shortest run that gets a run token
	localparam int LOW_BITS     = 5;   // count bits held in the run token
	localparam int LIT_BITS     = 7;   // pixels in a literal, bits per count group
	localparam int STEP_MAX     = 8;   // most words released per input word
	localparam int STEP_CAP     = 24;  // words kept per input word, released plus carried

	localparam logic [7:0] TOK_RUN = 8'h80;

	localparam int IQ_DEPTH   = 4;
	localparam int IQ_AW      = 2;
	localparam int IQ_CW      = 3;
	localparam int PEND_DEPTH = 32;
	localparam int PEND_AW    = 5;
	localparam int PEND_CW    = 6;
	localparam int REL_W      = 4;
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_AW     = 2;
	localparam int OUT_CW     = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} bire_in_t;

	typedef struct packed {
		logic [7:0] token_byte;
		logic       group_last;
		logic       image_last;
	} bire_out_t;

	// classified input word, front to engine
	typedef struct packed {
		logic [PIX_PER_WORD-1:0] pixels;
		logic [TAKE_W-1:0]       take;
		logic                    fin;
		logic [TOT_W-1:0]        pad;
	} bire_item_t;

	// buffered token
	typedef struct packed {
		logic [7:0] token_byte;
		logic       image_last;
	} bire_tok_t;

	// engine to collector
	typedef struct packed {
		logic       valid;
		logic [7:0] token_byte;
		logic       image_last;
		logic       step_end;
	} bire_emit_t;

endpackage

>>> hw/rtl/bire_front.sv
// Front end: accepts input words, works out pixel counts and queues them for the engine.
module bire_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  bire_pkg::bire_in_t        in_word,
	input  logic                      cfg_we,
	input  logic [bire_pkg::TOT_W-1:0] cfg_data,
	output logic                      item_valid,
	output bire_pkg::bire_item_t      item,
	input  logic                      item_pop
);
	import bire_pkg::*;

	logic [TOT_W-1:0] total_q, taken_q;
	logic             done_q;
	logic [TOT_W-1:0] rem;
	logic             near, reach, acc;
	bire_item_t       cls;

	bire_item_t       iq_q [IQ_DEPTH];
	logic [IQ_AW-1:0] iwr_q, ird_q;
	logic [IQ_CW-1:0] icnt_q;

	assign rem   = total_q - taken_q;
	assign near  = rem <= TOT_W'(PIX_PER_WORD);
	assign reach = !done_q && near;
	assign full  = icnt_q == IQ_CW'(IQ_DEPTH);
	assign acc   = push && !full;

	always_comb begin
		cls.pixels = in_word.data_byte;
		if (done_q)
			cls.take = '0;
		else if (near)
			cls.take = rem[TAKE_W-1:0];
		else
			cls.take = TAKE_W'(PIX_PER_WORD);
		cls.fin = !done_q && (near || in_word.end_of_data);
		// early end: zero pixels make up the rest of the image
		if (!done_q && in_word.end_of_data && !near)
			cls.pad = rem - TOT_W'(PIX_PER_WORD);
		else
			cls.pad = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOT_W'(1);
			taken_q <= '0;
			done_q  <= 1'b0;
		end else if (cfg_we) begin
			total_q <= cfg_data;
			taken_q <= '0;
			done_q  <= 1'b0;
		end else if (acc) begin
			if (in_word.end_of_data) begin
				taken_q <= '0;
				done_q  <= 1'b0;
			end else if (reach) begin
				done_q <= 1'b1;
			end else begin
				taken_q <= taken_q + TOT_W'(cls.take);
			end
		end
	end

	assign item_valid = icnt_q != '0;
	assign item       = iq_q[ird_q];

	always_ff @(posedge clk) begin
		if (acc)
			iq_q[iwr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iwr_q  <= '0;
			ird_q  <= '0;
			icnt_q <= '0;
		end else begin
			if (acc)
				iwr_q <= iwr_q + 1'b1;
			if (item_pop)
				ird_q <= ird_q + 1'b1;
			icnt_q <= icnt_q + IQ_CW'(acc) - IQ_CW'(item_pop);
		end
	end

endmodule

>>> hw/rtl/bire_engine.sv
// Back end: walks the pixels of each word and produces literal and run tokens.
module bire_engine #(
	parameter int PIXEL_COUNT_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 item_valid,
	input  bire_pkg::bire_item_t item,
	output logic                 item_pop,
	input  logic                 step_ready,
	output bire_pkg::bire_emit_t emit
);
	import bire_pkg::*;

	localparam int RL_W  = PIXEL_COUNT_BITS + 1;
	localparam int EXT_W = RL_W - LOW_BITS;
	localparam int SUM_W = ((RL_W > TOT_W) ? RL_W : TOT_W) + 1;
	localparam logic [RL_W-1:0] RL_MAX = '1;

	logic                    busy_q, busy_d;
	logic [PIX_PER_WORD-1:0] sh_q, sh_d;
	logic [TAKE_W-1:0]       take_q, take_d;
	logic [TOT_W-1:0]        pad_q, pad_d;
	logic                    fin_q, fin_d;
	logic [7:0]              win_q, win_d;
	logic [2:0]              fill_q, fill_d;
	logic                    in_run_q, in_run_d;
	logic                    rv_q, rv_d;
	logic [RL_W-1:0]         rl_q, rl_d;
	logic [EXT_W-1:0]        ext_q, ext_d;
	logic                    ext_last_q, ext_last_d;

	logic [RL_W-1:0]         cnt_run, rl_sat;
	logic [EXT_W-1:0]        cnt_ext, ext_next;
	logic [EXT_W+LIT_BITS-1:0] ext_wide;
	logic [LIT_BITS-1:0]     ext_part;
	logic [7:0]              run_tok, fin_lit, win_sh;
	logic [3:0]              fill_inc;
	logic [PIX_PER_WORD-1:0] tmask;
	logic                    fast_take, fast_pad;
	logic [SUM_W-1:0]        addend, sum;
	logic                    pix, do_feed, do_finish, step_fire, load;

	assign cnt_run  = (rl_q >= RL_W'(RUN_MIN)) ? rl_q - RL_W'(RUN_MIN) : '0;
	assign cnt_ext  = cnt_run[RL_W-1:LOW_BITS];
	assign run_tok  = TOK_RUN | {1'b0, rv_q, cnt_ext != '0, cnt_run[LOW_BITS-1:0]};
	assign ext_wide = {{LIT_BITS{1'b0}}, ext_q};
	assign ext_part = ext_wide[LIT_BITS-1:0];
	assign ext_next = ext_q >> LIT_BITS;
	assign fin_lit  = win_q << (3'(LIT_BITS) - fill_q);
	assign tmask    = ~({PIX_PER_WORD{1'b1}} >> take_q);

	// whole-word and padding shortcuts while the open run continues
	assign fast_take = in_run_q && (take_q != '0)
	                   && (((sh_q ^ {PIX_PER_WORD{rv_q}}) & tmask) == '0);
	assign fast_pad  = in_run_q && !rv_q && (take_q == '0) && (pad_q != '0);

	always_comb begin
		if (fast_take)
			addend = SUM_W'(take_q);
		else if (fast_pad)
			addend = SUM_W'(pad_q);
		else
			addend = SUM_W'(1);
	end

	assign sum    = SUM_W'(rl_q) + addend;
	assign rl_sat = (sum > SUM_W'(RL_MAX)) ? RL_MAX : sum[RL_W-1:0];

	always_comb begin
		busy_d     = busy_q;
		sh_d       = sh_q;
		take_d     = take_q;
		pad_d      = pad_q;
		fin_d      = fin_q;
		win_d      = win_q;
		fill_d     = fill_q;
		in_run_d   = in_run_q;
		rv_d       = rv_q;
		rl_d       = rl_q;
		ext_d      = ext_q;
		ext_last_d = ext_last_q;
		emit       = '0;
		pix        = 1'b0;
		do_feed    = 1'b0;
		do_finish  = 1'b0;
		step_fire  = 1'b0;

		if (ext_q != '0) begin
			// count groups of a run token, low group first
			emit.valid      = 1'b1;
			emit.token_byte = {ext_next != '0, ext_part};
			emit.image_last = (ext_next == '0) && ext_last_q;
			ext_d           = ext_next;
		end else if (busy_q) begin
			if (take_q != '0) begin
				if (fast_take) begin
					rl_d   = rl_sat;
					take_d = '0;
				end else begin
					pix     = sh_q[PIX_PER_WORD-1];
					do_feed = 1'b1;
					sh_d    = {sh_q[PIX_PER_WORD-2:0], 1'b0};
					take_d  = take_q - 1'b1;
				end
			end else if (pad_q != '0) begin
				if (fast_pad) begin
					rl_d  = rl_sat;
					pad_d = '0;
				end else begin
					do_feed = 1'b1;
					pad_d   = pad_q - 1'b1;
				end
			end else if (fin_q) begin
				do_finish = 1'b1;
				fin_d     = 1'b0;
			end else if (step_ready) begin
				step_fire     = 1'b1;
				emit.step_end = 1'b1;
				busy_d        = 1'b0;
			end
		end

		win_sh   = {win_q[6:0], pix};
		fill_inc = {1'b0, fill_q} + 4'd1;

		if (do_feed) begin
			if (in_run_q) begin
				if (pix == rv_q) begin
					rl_d = rl_sat;
				end else begin
					emit.valid      = 1'b1;
					emit.token_byte = run_tok;
					ext_d           = cnt_ext;
					ext_last_d      = 1'b0;
					in_run_d        = 1'b0;
					win_d           = {7'b0, pix};
					fill_d          = 3'd1;
				end
			end else if (fill_inc == 4'(RUN_MIN)) begin
				if (win_sh == '0 || win_sh == '1) begin
					in_run_d = 1'b1;
					rv_d     = pix;
					rl_d     = RL_W'(RUN_MIN);
					win_d    = '0;
					fill_d   = '0;
				end else begin
					emit.valid      = 1'b1;
					emit.token_byte = {1'b0, win_sh[7:1]};
					win_d           = {7'b0, pix};
					fill_d          = 3'd1;
				end
			end else begin
				win_d  = win_sh;
				fill_d = fill_inc[2:0];
			end
		end

		if (do_finish) begin
			if (in_run_q) begin
				emit.valid      = 1'b1;
				emit.token_byte = run_tok;
				emit.image_last = cnt_ext == '0;
				ext_d           = cnt_ext;
				ext_last_d      = 1'b1;
			end else if (fill_q != '0) begin
				// partial literal, left aligned
				emit.valid      = 1'b1;
				emit.token_byte = {1'b0, fin_lit[LIT_BITS-1:0]};
				emit.image_last = 1'b1;
			end
			in_run_d = 1'b0;
			win_d    = '0;
			fill_d   = '0;
		end

		load     = item_valid && (!busy_q || step_fire);
		item_pop = load;
		if (load) begin
			busy_d = 1'b1;
			sh_d   = item.pixels;
			take_d = item.take;
			pad_d  = item.pad;
			fin_d  = item.fin;
		end
	end

	always_ff @(posedge clk) begin
		sh_q <= sh_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			take_q     <= '0;
			pad_q      <= '0;
			fin_q      <= 1'b0;
			win_q      <= '0;
			fill_q     <= '0;
			in_run_q   <= 1'b0;
			rv_q       <= 1'b0;
			rl_q       <= '0;
			ext_q      <= '0;
			ext_last_q <= 1'b0;
		end else begin
			busy_q     <= busy_d;
			take_q     <= take_d;
			pad_q      <= pad_d;
			fin_q      <= fin_d;
			win_q      <= win_d;
			fill_q     <= fill_d;
			in_run_q   <= in_run_d;
			rv_q       <= rv_d;
			rl_q       <= rl_d;
			ext_q      <= ext_d;
			ext_last_q <= ext_last_d;
			// new image: drop pixel state
			if (cfg_we) begin
				win_q    <= '0;
				fill_q   <= '0;
				in_run_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/bire_collect.sv
// Result side: groups tokens per input word, carries the overflow, output queue.
module bire_collect (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bire_pkg::bire_emit_t emit,
	output logic                 step_ready,
	output logic                 empty,
	input  logic                 pop,
	output bire_pkg::bire_out_t  out_word
);
	import bire_pkg::*;

	bire_tok_t          pend_q [PEND_DEPTH];
	logic [PEND_AW-1:0] pwr_q, prd_q;
	logic [PEND_CW-1:0] pcnt_q, step_pos;
	logic [REL_W-1:0]   rel_q;

	bire_out_t          ofifo_q [OUT_DEPTH];
	logic [OUT_AW-1:0]  owr_q, ord_q;
	logic [OUT_CW-1:0]  ocnt_q;

	logic app, rel, opop;
	bire_out_t rel_word;

	// place of the next token in the current word's list, carried words first
	assign step_pos   = pcnt_q - PEND_CW'(rel_q);
	assign app        = emit.valid && (step_pos < PEND_CW'(STEP_CAP));
	assign rel        = (rel_q != '0) && (ocnt_q != OUT_CW'(OUT_DEPTH));
	assign opop       = pop && !empty;
	assign step_ready = rel_q == '0;

	assign rel_word.token_byte = pend_q[prd_q].token_byte;
	assign rel_word.image_last = pend_q[prd_q].image_last;
	assign rel_word.group_last = rel_q == REL_W'(1);

	assign empty    = ocnt_q == '0;
	assign out_word = ofifo_q[ord_q];

	always_ff @(posedge clk) begin
		if (app) begin
			pend_q[pwr_q].token_byte <= emit.token_byte;
			pend_q[pwr_q].image_last <= emit.image_last;
		end
		if (rel)
			ofifo_q[owr_q] <= rel_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwr_q  <= '0;
			prd_q  <= '0;
			pcnt_q <= '0;
			rel_q  <= '0;
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (app)
				pwr_q <= pwr_q + 1'b1;
			if (rel)
				prd_q <= prd_q + 1'b1;
			pcnt_q <= pcnt_q + PEND_CW'(app) - PEND_CW'(rel);
			if (emit.step_end) begin
				if (pcnt_q > PEND_CW'(STEP_MAX))
					rel_q <= REL_W'(STEP_MAX);
				else
					rel_q <= pcnt_q[REL_W-1:0];
			end else if (rel) begin
				rel_q <= rel_q - 1'b1;
			end
			if (rel)
				owr_q <= owr_q + 1'b1;
			if (opop)
				ord_q <= ord_q + 1'b1;
			ocnt_q <= ocnt_q + OUT_CW'(rel) - OUT_CW'(opop);
		end
	end

endmodule

>>> hw/rtl/bilevel_image_rle_encoder_top.sv
// Top level of the bilevel image run-length encoder.
//
// Input queue: a word (eight pixels, first pixel in bit 7, plus end_of_data)
// is taken at a clock edge with push high and full low. Up to four words
// wait ahead of the pixel engine, so pushing goes on while it is busy.
// Result queue: while empty is low, out_word holds the oldest token byte;
// pop high at a clock edge takes it. A stalled receiver only fills the
// queues; once they are full, full rises and input waits. Nothing is lost.
// Configuration: cfg_data is total_pixels, written when cfg_valid is high
// (cfg_ready is always high). Write it only with the block idle.
// Tokens of one input word are released together, at most eight, with
// group_last on the last; the overflow waits for the next input word.
// The engine walks each word pixel by pixel, but takes the rest of a word
// that carries on the open run at once; each count extension byte, the
// close of an image and the close of each word take a step of their own.
// A word also waits until the previous word's tokens are released, one
// byte per cycle while the result queue has room.
// Reset: queues empty, no image open, total_pixels is 1.
module bilevel_image_rle_encoder_top #(
	parameter int PIXEL_COUNT_BITS = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  bire_pkg::bire_in_t         in_word,
	output logic                       empty,
	input  logic                       pop,
	output bire_pkg::bire_out_t        out_word,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bire_pkg::TOT_W-1:0] cfg_data
);
	import bire_pkg::*;

	logic       cfg_we;
	logic       item_valid, item_pop, step_ready;
	bire_item_t item;
	bire_emit_t emit;

	// configuration never stalls
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// front: pixel bookkeeping per word, short queue to the engine
	bire_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_word    (in_word),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// engine: pixel window, run counter and token formatting
	bire_engine #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.step_ready (step_ready),
		.emit       (emit)
	);

	// collector: per-word grouping, carry buffer and result queue
	bire_collect u_collect (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit       (emit),
		.step_ready (step_ready),
		.empty      (empty),
		.pop        (pop),
		.out_word   (out_word)
	);

endmodule
